// File: rtl/core/shst_pkg.sv
// package: sizes, codes and hash helper for the scoped symbol table
package shst_pkg;
  localparam int TableDepth = 128;
  localparam int Buckets    = 128;
  localparam int MaxLevels  = 10;
  localparam int NameBytes  = 8;
  localparam int IdxW = $clog2(TableDepth);
  localparam int CntW = $clog2(TableDepth + 1);
  localparam int BktW = $clog2(Buckets);
  localparam int LvlW = $clog2(MaxLevels + 1);
  localparam int StepW = $clog2(TableDepth + 1);

  typedef enum logic [2:0] {
    ST_OK = 3'd0, ST_FULL = 3'd1, ST_NOT_FOUND = 3'd2,
    ST_DUPLICATE = 3'd3, ST_BAD_TYPE = 3'd4, ST_NO_BLOCK = 3'd5
  } status_t;

  typedef enum logic [2:0] {
    OP_ENTER = 3'd0, OP_EXIT = 3'd1, OP_INSTALL = 3'd2,
    OP_LOOKUP = 3'd3, OP_ASSIGN = 3'd4
  } op_t;

  localparam logic [2:0] TypeInvalid = 3'd4;

  typedef enum logic [3:0] {
    S_IDLE, S_HEAD, S_HEAD_W, S_WALK_RD, S_WALK_CHK, S_INSTALL,
    S_EXIT_RD, S_EXIT_W, S_EXIT_UPD, S_DONE
  } state_t;

  function automatic logic [63:0] name_mask();
    logic [63:0] m;
    m = '0;
    for (int i = 0; i < NameBytes; i++) m[63 - 8*i -: 8] = 8'hff;
    return m;
  endfunction

  function automatic logic [BktW-1:0] bucket_of(input logic [63:0] nm);
    logic [10:0] s;
    s = '0;
    for (int i = 0; i < 8; i++) s = s + 11'(nm[8*i +: 8]);
    return BktW'(s % Buckets);
  endfunction
endpackage

// File: rtl/core/shst_ram.sv
// generic single port ram with registered read
module shst_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] addr,
  input  logic [Width-1:0]         wdata,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];
  always_ff @(posedge clk) begin
    if (we) mem[addr] <= wdata;
    rdata <= mem[addr];
  end
endmodule

// File: rtl/core/scoped_hash_symbol_table.sv
// top level: sequencer over entry and bucket memories
// channel | ports                                          | dir
// command | start, busy (out), in_mode, in_symbol_name, in_type_in, in_attribute_in | in
// result  | out_valid, out_status, out_entry_index, out_entry_level, out_entry_type | out
// enter needs no walk; install/lookup/assign walk the bucket chain one entry at a time;
// exit walks back over the entries of the level, unlinking each from its bucket; these
// chain and scope walks go through the single port of each memory
// after reset a clearing pass over all 128 bucket heads empties them, busy high
// results show for one cycle with out_valid; the receiver cannot stall
module scoped_hash_symbol_table (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   start,
  output logic                   busy,
  input  logic [2:0]             in_mode,
  input  logic [63:0]            in_symbol_name,
  input  logic [2:0]             in_type_in,
  input  logic [63:0]            in_attribute_in,
  output logic                   out_valid,
  output logic [2:0]             out_status,
  output logic [6:0]             out_entry_index,
  output logic [3:0]             out_entry_level,
  output logic [2:0]             out_entry_type
);
  import shst_pkg::*;

  state_t state_r, state_nxt;
  logic [63:0] name_r, attr_r;
  logic [2:0] mode_r, type_r;
  logic [LvlW-1:0] lvl_r, lvl_nxt;
  logic [CntW-1:0] free_r, free_nxt;
  logic [CntW-1:0] base_r [MaxLevels+1];
  logic [IdxW-1:0] k_r, k_nxt;
  logic [StepW-1:0] steps_r, steps_nxt;
  logic [CntW-1:0] s_r, s_nxt;
  logic clr_r;
  logic [BktW-1:0] clr_cnt_r;
  logic [2:0] st_r, st_nxt;
  logic [IdxW-1:0] oi_r, oi_nxt;
  logic [LvlW-1:0] ol_r, ol_nxt;
  logic [2:0] ot_r, ot_nxt;
  logic done_nxt;

  // entry memory: name, level, type, link packed; attributes apart
  localparam int EntW = 64 + LvlW + 3 + IdxW;
  logic ent_we, attr_we, bkt_we;
  logic [IdxW-1:0] ent_addr;
  logic [EntW-1:0] ent_wd, ent_rd;
  logic [63:0] attr_wd, attr_rd;
  logic [BktW-1:0] bkt_addr;
  logic [IdxW-1:0] bkt_wd, bkt_rd;

  shst_ram #(.Width(EntW), .Depth(TableDepth)) u_ent (
    .clk(clk), .we(ent_we), .addr(ent_addr), .wdata(ent_wd), .rdata(ent_rd));
  shst_ram #(.Width(64), .Depth(TableDepth)) u_attr (
    .clk(clk), .we(attr_we), .addr(ent_addr), .wdata(attr_wd), .rdata(attr_rd));
  shst_ram #(.Width(IdxW), .Depth(Buckets)) u_bkt (
    .clk(clk), .we(bkt_we), .addr(bkt_addr), .wdata(bkt_wd), .rdata(bkt_rd));

  logic [63:0] rd_name;
  logic [LvlW-1:0] rd_lvl;
  logic [2:0] rd_type;
  logic [IdxW-1:0] rd_link;
  assign {rd_name, rd_lvl, rd_type, rd_link} = ent_rd;

  logic [CntW-1:0] min_base;
  assign min_base = (mode_r == OP_INSTALL) ? base_r[lvl_r] : CntW'(1);
  logic [BktW-1:0] name_bkt;
  assign name_bkt = bucket_of(name_r);

  assign busy = (state_r != S_IDLE) || clr_r;

  always_comb begin
    state_nxt = state_r;
    priority case (state_r)
      S_IDLE:    if (start && !clr_r) begin
        priority case (in_mode)
          OP_EXIT:    state_nxt = (lvl_r <= LvlW'(1)) ? S_DONE : S_EXIT_RD;
          OP_INSTALL, OP_LOOKUP, OP_ASSIGN: state_nxt = S_HEAD;
          default:    state_nxt = S_DONE;
        endcase
      end
      S_HEAD:    state_nxt = S_HEAD_W;
      S_HEAD_W:  state_nxt = S_WALK_CHK;
      S_WALK_RD: state_nxt = S_WALK_CHK;
      S_WALK_CHK: begin
        if (k_r == '0 || CntW'(k_r) < min_base || steps_r >= StepW'(TableDepth))
          state_nxt = (mode_r == OP_INSTALL) ? S_INSTALL : S_DONE;
        else if (k_r != '0 && rd_name == name_r) state_nxt = S_DONE;
        else state_nxt = S_WALK_RD;
      end
      S_INSTALL: state_nxt = S_DONE;
      S_EXIT_RD: state_nxt = (s_r > base_r[lvl_r]) ? S_EXIT_W : S_DONE;
      S_EXIT_W:  state_nxt = S_EXIT_UPD;
      S_EXIT_UPD: state_nxt = S_EXIT_RD;
      S_DONE:    state_nxt = S_IDLE;
      default:   state_nxt = S_IDLE;
    endcase
  end

  // S_WALK_CHK sees the read of k_r issued in the previous cycle
  always_comb begin
    lvl_nxt = lvl_r; free_nxt = free_r; k_nxt = k_r; steps_nxt = steps_r;
    s_nxt = s_r; st_nxt = st_r; oi_nxt = oi_r; ol_nxt = ol_r; ot_nxt = ot_r;
    ent_we = 1'b0; attr_we = 1'b0; bkt_we = 1'b0;
    ent_addr = k_r; ent_wd = '0; attr_wd = attr_r;
    bkt_addr = name_bkt; bkt_wd = '0;
    done_nxt = 1'b0;
    if (clr_r) begin
      bkt_we = 1'b1; bkt_addr = clr_cnt_r;
    end
    unique case (state_r)
      S_IDLE: begin
        st_nxt = ST_OK; oi_nxt = '0; ol_nxt = '0; ot_nxt = TypeInvalid;
        steps_nxt = '0; s_nxt = free_r;
        if (start && !clr_r) begin
          if (in_mode == OP_ENTER) begin
            if (lvl_r >= LvlW'(MaxLevels)) st_nxt = ST_FULL;
            else lvl_nxt = lvl_r + LvlW'(1);
          end else if (in_mode == OP_EXIT && lvl_r <= LvlW'(1)) begin
            st_nxt = ST_NO_BLOCK;
          end
        end
      end
      S_HEAD: ;
      S_HEAD_W: begin k_nxt = bkt_rd; ent_addr = bkt_rd; end
      S_WALK_RD: ;
      S_WALK_CHK: begin
        if (k_r == '0 || CntW'(k_r) < min_base || steps_r >= StepW'(TableDepth)) begin
          if (mode_r != OP_INSTALL) st_nxt = ST_NOT_FOUND;
        end else if (rd_name == name_r) begin
          oi_nxt = k_r; ol_nxt = rd_lvl; ot_nxt = rd_type;
          if (mode_r == OP_INSTALL) st_nxt = ST_DUPLICATE;
          if (mode_r == OP_ASSIGN) attr_we = 1'b1;
        end else begin
          k_nxt = rd_link; ent_addr = rd_link; steps_nxt = steps_r + StepW'(1);
        end
      end
      S_INSTALL: begin
        if (free_r >= CntW'(TableDepth)) st_nxt = ST_FULL;
        else begin
          ent_addr = IdxW'(free_r);
          ent_we = 1'b1; attr_we = 1'b1; attr_wd = '0; bkt_we = 1'b1;
          bkt_wd = IdxW'(free_r);
          ent_wd = {name_r, lvl_r, (type_r < TypeInvalid) ? type_r : TypeInvalid,
                    bkt_rd};
          free_nxt = free_r + CntW'(1);
          st_nxt = (type_r < TypeInvalid) ? ST_OK : ST_BAD_TYPE;
          oi_nxt = IdxW'(free_r); ol_nxt = lvl_r;
          ot_nxt = (type_r < TypeInvalid) ? type_r : TypeInvalid;
        end
      end
      S_EXIT_RD: begin
        if (s_r > base_r[lvl_r]) begin
          s_nxt = s_r - CntW'(1); ent_addr = IdxW'(s_r - CntW'(1));
        end else begin
          free_nxt = base_r[lvl_r]; lvl_nxt = lvl_r - LvlW'(1);
        end
      end
      S_EXIT_W: ent_addr = IdxW'(s_r);
      S_EXIT_UPD: begin
        bkt_we = 1'b1; bkt_addr = bucket_of(rd_name); bkt_wd = rd_link;
      end
      S_DONE: done_nxt = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE; lvl_r <= LvlW'(1); free_r <= CntW'(1);
      clr_r <= 1'b1; clr_cnt_r <= '0; out_valid <= 1'b0;
      for (int i = 0; i <= MaxLevels; i++) base_r[i] <= CntW'(1);
    end else begin
      state_r <= state_nxt; lvl_r <= lvl_nxt; free_r <= free_nxt;
      out_valid <= done_nxt;
      if (clr_r) begin
        clr_cnt_r <= clr_cnt_r + BktW'(1);
        if (clr_cnt_r == BktW'(Buckets - 1)) clr_r <= 1'b0;
      end
      if (state_r == S_IDLE && start && !clr_r && in_mode == OP_ENTER &&
          lvl_r < LvlW'(MaxLevels))
        base_r[lvl_r + LvlW'(1)] <= free_r;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_IDLE && start) begin
      name_r <= in_symbol_name & name_mask(); attr_r <= in_attribute_in;
      mode_r <= in_mode; type_r <= in_type_in;
    end
    k_r <= k_nxt; steps_r <= steps_nxt; s_r <= s_nxt;
    st_r <= st_nxt; oi_r <= oi_nxt; ol_r <= ol_nxt; ot_r <= ot_nxt;
  end

  assign out_status      = st_r;
  assign out_entry_index = oi_r;
  assign out_entry_level = ol_r;
  assign out_entry_type  = ot_r;

`ifndef SYNTHESIS
  a_lvl_range: assert property (@(posedge clk) disable iff (!rst_n)
    lvl_r >= LvlW'(1) && lvl_r <= LvlW'(MaxLevels)) else $error("level out of range");
  a_free_range: assert property (@(posedge clk) disable iff (!rst_n)
    free_r >= CntW'(1) && free_r <= CntW'(TableDepth)) else $error("free index out of range");
  a_valid_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> state_r == S_IDLE) else $error("result while busy");
  a_busy_clr: assert property (@(posedge clk) disable iff (!rst_n)
    clr_r |-> busy) else $error("accepting during clear");
`endif
endmodule
